@@ design/shr_pkg.sv @@
// shared types and constants for the stamped history ring
package shr_pkg;

	localparam int STAMP_BITS       = 32;
	localparam int PAYLOAD_MAX      = 64;
	localparam int AGE_BITS         = 16;
	localparam int DEPTH_DEF        = 32;
	localparam int PAYLOAD_BITS_DEF = 64;
	// command queue depth, a power of two
	localparam int QUEUE_DEPTH      = 4;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_PUSH  = 2'd1,
		KIND_FIND  = 2'd2,
		KIND_FETCH = 2'd3
	} kind_t;

	// classified command handed from front to back
	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PUSH,
		OP_FIND,
		OP_FETCH,
		OP_MISS
	} op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SCAN,
		BK_FETCH,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		kind_t                   kind;
		logic [STAMP_BITS-1:0]   key_stamp;
		logic [PAYLOAD_MAX-1:0]  pose_payload;
		logic [AGE_BITS-1:0]     age;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic [STAMP_BITS-1:0]   hit_stamp;
		logic [PAYLOAD_MAX-1:0]  hit_payload;
	} rsp_t;

	typedef struct packed {
		op_t                     op;
		logic [STAMP_BITS-1:0]   stamp;
		logic [PAYLOAD_MAX-1:0]  payload;
		logic [AGE_BITS-1:0]     age;
	} cmd_t;

endpackage

@@ design/shr_front.sv @@
// front end: takes request items and classifies them into commands
module shr_front import shr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	input  logic q_full,
	input  logic init_busy,
	output logic q_push,
	output cmd_t q_cmd
);

	// hold off while the queue is full or the ring is being initialized
	assign req_stall = q_full | init_busy;
	assign q_push    = req_valid & ~req_stall;

	// classify, turning lookups that cannot hit into plain misses
	always_comb begin
		q_cmd.stamp   = req.key_stamp;
		q_cmd.payload = req.pose_payload;
		q_cmd.age     = req.age;
		case (req.kind)
			KIND_CLEAR: q_cmd.op = OP_CLEAR;
			KIND_PUSH:  q_cmd.op = OP_PUSH;
			KIND_FIND: begin
				q_cmd.op = (req.key_stamp == '0) ? OP_MISS : OP_FIND;
			end
			KIND_FETCH: begin
				if (req.age == '0 || req.age > AGE_BITS'(DEPTH))
					q_cmd.op = OP_MISS;
				else
					q_cmd.op = OP_FETCH;
			end
			default: q_cmd.op = OP_MISS;
		endcase
	end

endmodule

@@ design/shr_queue.sv @@
// short command queue between front and back
module shr_queue import shr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = slot_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QAW'(1);
			if (pop)
				rd_q <= rd_q + QAW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/shr_back.sv @@
// back end: ring memory, write pointer, clear sweep, stamp scan and result register
module shr_back import shr_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic init_busy,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int WW = STAMP_BITS + PAYLOAD_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	logic [WW-1:0]          ring_mem_q [DEPTH];
	logic [WW-1:0]          rd_data_q;
	back_state_t            state_q, state_d;
	logic [AW-1:0]          wp_q;
	logic [CW-1:0]          idx_q;
	logic [STAMP_BITS-1:0]  key_q;
	logic                   hit_q;
	logic                   init_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic [WW-1:0]          mem_wd;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   rsp_load;

	logic [STAMP_BITS-1:0]   rd_stamp;
	logic [PAYLOAD_BITS-1:0] rd_payload;
	logic                    match;
	logic                    scan_end;
	logic                    clear_end;
	logic                    slot_free;
	logic [CW-1:0]           age_gap;
	logic [CW-1:0]           fsum;
	logic [AW-1:0]           fetch_addr;

	assign rd_stamp   = rd_data_q[WW-1 -: STAMP_BITS];
	assign rd_payload = rd_data_q[PAYLOAD_BITS-1:0];
	assign match      = (rd_stamp == key_q);
	assign scan_end   = (idx_q == DEPTH_C);
	assign clear_end  = (idx_q == DEPTH_C - CW'(1));
	assign slot_free  = ~rsp_valid_q | ~rsp_stall;

	// slot written age pushes ago; the sum stays below twice the depth
	assign age_gap    = DEPTH_C - q_cmd.age[CW-1:0];
	assign fsum       = {1'b0, wp_q} + age_gap;
	assign fetch_addr = (fsum >= DEPTH_C) ? AW'(fsum - DEPTH_C) : fsum[AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clear_end)
					state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_CLEAR: state_d = BK_CLEAR;
						OP_FIND:  state_d = BK_SCAN;
						OP_FETCH: state_d = BK_FETCH;
						OP_MISS:  state_d = BK_DONE;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_SCAN: begin
				if (match || scan_end)
					state_d = BK_DONE;
			end
			BK_FETCH: state_d = BK_DONE;
			BK_DONE: begin
				if (slot_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = wp_q;
		mem_wd   = {q_cmd.stamp, q_cmd.payload[PAYLOAD_BITS-1:0]};
		rd_en    = 1'b0;
		rd_addr  = '0;
		rsp_load = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = idx_q[AW-1:0];
				mem_wd = '0;
			end
			BK_IDLE: begin
				q_pop = q_valid;
				case (q_cmd.op)
					OP_PUSH:  mem_we = q_valid;
					OP_FIND:  rd_en  = q_valid;
					OP_FETCH: begin
						rd_en   = q_valid;
						rd_addr = fetch_addr;
					end
					default: mem_we = 1'b0;
				endcase
			end
			BK_SCAN: begin
				rd_en   = ~match & ~scan_end;
				rd_addr = idx_q[AW-1:0];
			end
			BK_DONE: rsp_load = slot_free;
			default: rsp_load = 1'b0;
		endcase
	end

	// ring memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem_q[mem_wa] <= mem_wd;
		if (rd_en)
			rd_data_q <= ring_mem_q[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			wp_q        <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			init_q      <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_CLEAR: begin
					idx_q <= idx_q + CW'(1);
					if (clear_end)
						init_q <= 1'b0;
				end
				BK_IDLE: begin
					hit_q <= 1'b0;
					if (q_valid) begin
						case (q_cmd.op)
							OP_CLEAR: begin
								idx_q <= '0;
								wp_q  <= '0;
							end
							OP_PUSH:  wp_q  <= (wp_q == LAST) ? '0 : wp_q + AW'(1);
							OP_FIND:  idx_q <= CW'(1);
							default:  idx_q <= idx_q;
						endcase
					end
				end
				BK_SCAN: begin
					hit_q <= match;
					if (!match && !scan_end)
						idx_q <= idx_q + CW'(1);
				end
				BK_FETCH: hit_q <= (rd_stamp != '0);
				default:  hit_q <= hit_q;
			endcase
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// search key and result register
	always_ff @(posedge clk) begin
		if (q_pop)
			key_q <= q_cmd.stamp;
		if (rsp_load) begin
			rsp_q.hit         <= hit_q;
			rsp_q.hit_stamp   <= hit_q ? rd_stamp : '0;
			rsp_q.hit_payload <= hit_q ? PAYLOAD_MAX'(rd_payload) : '0;
		end
	end

	assign init_busy = init_q;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ design/stamped_history_ring.sv @@
// top level of the stamped history ring
//
//  channel  | direction | payload | handshake
//  ---------+-----------+---------+----------------------
//  request  | in        | req_t   | req_valid / req_stall
//  response | out       | rsp_t   | rsp_valid / rsp_stall
//
// a push writes one slot, a fetch reads one, a clear writes one slot per cycle; a find
// reads one slot per cycle from slot zero upward, as the ring memory has a single read port.
// after reset the ring is zeroed in a sweep while req_stall is high.
// a queue of QUEUE_DEPTH commands lets requests enter while a response is stalled.
module stamped_history_ring import shr_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	logic init_busy;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	// classification of request items
	shr_front #(
		.DEPTH(DEPTH)
	) u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.q_full    (q_full),
		.init_busy (init_busy),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	// command queue
	shr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (pop_cmd)
	);

	// ring storage and execution
	shr_back #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

@@ design/shr_checker.sv @@
// port-level checks for the stamped history ring, bound to the top level
module shr_checker import shr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input req_t req,
	input logic req_valid,
	input logic req_stall,
	input rsp_t rsp,
	input logic rsp_valid,
	input logic rsp_stall
);

	// a stalled response item stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// a stalled response item keeps its contents
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("response changed while stalled");

	// a miss carries an all-zero record
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.hit_stamp == '0 && rsp.hit_payload == '0)
		else $error("miss with nonzero record");

	// empty slots never report a hit
	a_hit_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.hit_stamp != '0)
		else $error("hit on an empty stamp");

endmodule

bind stamped_history_ring shr_checker u_shr_checker (.*);

@@ sim/stamped_history_ring_tb.sv @@
// testbench for stamped_history_ring: directed and random items, scoreboard against a predictor
module stamped_history_ring_tb;
	import shr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int              RANDOM_ITEMS = 1680;
	localparam int              HOLD_CYCLES  = 300;
	localparam int              HOLD_AT_ITEM = 400;
	localparam int              QUIET_FIRST  = 900;
	localparam int              QUIET_LAST   = 1250;
	localparam int              DRAIN_CYCLES = 2 * DEPTH_DEF + 8;
	localparam int              CYCLE_LIMIT  = 600000;
	localparam logic [PAYLOAD_MAX-1:0] PAYLOAD_MASK = (PAYLOAD_BITS_DEF >= PAYLOAD_MAX) ?
		{PAYLOAD_MAX{1'b1}} : ((64'd1 << PAYLOAD_BITS_DEF) - 64'd1);

	// scoreboard: mirrors the ring contents and queues the expected lookup answers
	class ring_scoreboard;
		logic [STAMP_BITS-1:0]  stamp_mem [DEPTH_DEF];
		logic [PAYLOAD_MAX-1:0] payload_mem [DEPTH_DEF];
		int                     next_slot;
		rsp_t                   awaited_lookups [$];
		int                     errors;
		int                     n_clear;
		int                     n_push;
		int                     n_find;
		int                     n_fetch;
		int                     n_hit;
		int                     n_miss;

		function new();
			wipe();
			errors  = 0;
			n_clear = 0;
			n_push  = 0;
			n_find  = 0;
			n_fetch = 0;
			n_hit   = 0;
			n_miss  = 0;
		endfunction

		function void wipe();
			for (int i = 0; i < DEPTH_DEF; i++) begin
				stamp_mem[i]   = '0;
				payload_mem[i] = '0;
			end
			next_slot = 0;
		endfunction

		function int pending();
			return awaited_lookups.size();
		endfunction

		// update the mirror for an accepted item, queue an answer for lookups
		function void note_request(req_t item);
			rsp_t lookup;
			int   slot;
			lookup = '0;
			slot   = -1;
			case (item.kind)
			KIND_CLEAR: begin
				wipe();
				n_clear++;
			end
			KIND_PUSH: begin
				stamp_mem[next_slot]   = item.key_stamp;
				payload_mem[next_slot] = item.pose_payload & PAYLOAD_MASK;
				next_slot              = (next_slot + 1) % DEPTH_DEF;
				n_push++;
			end
			KIND_FIND: begin
				// scan downward so the lowest matching slot is the one kept
				if (item.key_stamp != '0)
					for (int i = DEPTH_DEF - 1; i >= 0; i--)
						if (stamp_mem[i] == item.key_stamp)
							slot = i;
				n_find++;
			end
			default: begin
				// newest record sits just behind the write pointer
				if (item.age != '0 && int'(item.age) <= DEPTH_DEF) begin
					slot = (next_slot + DEPTH_DEF - int'(item.age)) % DEPTH_DEF;
					if (stamp_mem[slot] == '0)
						slot = -1;
				end
				n_fetch++;
			end
			endcase
			if (item.kind == KIND_FIND || item.kind == KIND_FETCH) begin
				if (slot >= 0) begin
					lookup.hit         = 1'b1;
					lookup.hit_stamp   = stamp_mem[slot];
					lookup.hit_payload = payload_mem[slot];
				end
				awaited_lookups.push_back(lookup);
			end
		endfunction

		// compare an accepted response with the oldest queued answer
		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited_lookups.size() == 0) begin
				$error("response with no lookup outstanding: hit %0b stamp %h payload %h",
					got.hit, got.hit_stamp, got.hit_payload);
				errors++;
				return;
			end
			want = awaited_lookups.pop_front();
			if (want.hit)
				n_hit++;
			else
				n_miss++;
			if (got.hit !== want.hit) begin
				$error("hit: expected %0b, actual %0b", want.hit, got.hit);
				errors++;
			end
			if (got.hit_stamp !== want.hit_stamp) begin
				$error("hit_stamp: expected %h, actual %h", want.hit_stamp, got.hit_stamp);
				errors++;
			end
			if (got.hit_payload !== want.hit_payload) begin
				$error("hit_payload: expected %h, actual %h", want.hit_payload, got.hit_payload);
				errors++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	req_t  req;
	logic  req_valid;
	logic  req_stall;
	rsp_t  rsp;
	logic  rsp_valid;
	logic  rsp_stall;

	ring_scoreboard sb = new();
	int             items_sent   = 0;
	int             cycle_count  = 0;
	int             stall_cycles = 0;
	bit             quiet_run    = 1'b0;
	bit             hold_done    = 1'b0;

	stamped_history_ring u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle count and input back-pressure count
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (req_valid && req_stall)
			stall_cycles <= stall_cycles + 1;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	function automatic req_t make_req(kind_t kind, logic [STAMP_BITS-1:0] stamp,
			logic [PAYLOAD_MAX-1:0] payload, logic [AGE_BITS-1:0] age);
		req_t item;
		item.kind         = kind;
		item.key_stamp    = stamp;
		item.pose_payload = payload;
		item.age          = age;
		return item;
	endfunction

	// random item: stamps mostly from a small pool so finds hit, ages mostly from zero to just past the depth
	function automatic req_t random_req();
		req_t item;
		int   pick;
		int   sub;
		item.key_stamp    = $urandom;
		item.pose_payload = {$urandom, $urandom};
		item.age          = AGE_BITS'($urandom);
		pick              = $urandom_range(0, 99);
		sub               = $urandom_range(0, 99);
		if (pick < 2) begin
			item.kind = KIND_CLEAR;
		end else if (pick < 45) begin
			item.kind = KIND_PUSH;
			if (sub < 80)
				item.key_stamp = $urandom_range(1, 64);
			else if (sub < 88)
				item.key_stamp = '0;
		end else if (pick < 72) begin
			item.kind = KIND_FIND;
			if (sub < 75)
				item.key_stamp = $urandom_range(1, 64);
			else if (sub < 85)
				item.key_stamp = '0;
		end else begin
			item.kind = KIND_FETCH;
			if (sub < 85)
				item.age = AGE_BITS'($urandom_range(0, DEPTH_DEF + 2));
		end
		return item;
	endfunction

	// offer one item, idling at random first, and wait for it to be taken
	task automatic send_item(req_t item);
		while (!quiet_run && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(item);
		items_sent++;
	endtask

	// response side: check accepted items, then pick the next stall value
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (quiet_run) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < 33);
			end
		end
	end

	// reset, directed items, random items, drain, verdict
	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty ring, extremes, zero stamp, age limits, duplicate stamps, clear
		send_item(make_req(KIND_FETCH, '0, '0, 16'd1));
		send_item(make_req(KIND_FIND, '0, '0, '0));
		send_item(make_req(KIND_PUSH, 32'hFFFF_FFFF, {PAYLOAD_MAX{1'b1}}, 16'hFFFF));
		send_item(make_req(KIND_PUSH, 32'd1, '0, '0));
		send_item(make_req(KIND_PUSH, '0, 64'hA5A5_5A5A_C3C3_3C3C, 16'd7));
		send_item(make_req(KIND_FIND, 32'hFFFF_FFFF, '0, '0));
		send_item(make_req(KIND_FIND, '0, {PAYLOAD_MAX{1'b1}}, '0));
		send_item(make_req(KIND_FETCH, '0, '0, 16'd0));
		send_item(make_req(KIND_FETCH, '0, '0, 16'd1));
		send_item(make_req(KIND_FETCH, '0, '0, 16'd2));
		send_item(make_req(KIND_FETCH, '0, '0, 16'd3));
		send_item(make_req(KIND_FETCH, '0, '0, 16'(DEPTH_DEF)));
		send_item(make_req(KIND_FETCH, '0, '0, 16'(DEPTH_DEF + 1)));
		send_item(make_req(KIND_FETCH, 32'hFFFF_FFFF, '0, 16'hFFFF));
		send_item(make_req(KIND_PUSH, 32'd1, 64'h1234_5678_9ABC_DEF0, '0));
		send_item(make_req(KIND_FIND, 32'd1, '0, '0));
		send_item(make_req(KIND_FIND, 32'd2, '0, '0));
		send_item(make_req(KIND_CLEAR, 32'hFFFF_FFFF, {PAYLOAD_MAX{1'b1}}, 16'hFFFF));
		send_item(make_req(KIND_FIND, 32'hFFFF_FFFF, '0, '0));
		send_item(make_req(KIND_FETCH, '0, '0, 16'd1));
		send_item(make_req(KIND_PUSH, 32'd7, 64'h0F0F_F0F0_0000_FFFF, '0));
		send_item(make_req(KIND_FETCH, '0, '0, 16'd1));
		send_item(make_req(KIND_FIND, 32'd7, '0, '0));

		// random traffic with a stretch free of idling on both sides
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet_run = (n >= QUIET_FIRST && n <= QUIET_LAST);
			send_item(random_req());
		end
		quiet_run = 1'b0;
		req_valid <= 1'b0;

		// drain outstanding lookups, then allow for any late extra response
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d pushes, %0d clears, %0d finds, %0d fetches (%0d hits, %0d misses)",
			sb.n_push, sb.n_clear, sb.n_find, sb.n_fetch, sb.n_hit, sb.n_miss);
		$display("response hold-off of %0d cycles; request side stalled for %0d cycles",
			HOLD_CYCLES, stall_cycles);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/shr_pkg.sv
design/shr_front.sv
design/shr_queue.sv
design/shr_back.sv
design/stamped_history_ring.sv
design/shr_checker.sv
sim/stamped_history_ring_tb.sv
